>>> rtl/core/vtsd_pkg.sv
// ----------------------------------------------------------------------------
// vtsd_pkg
// Shared types, codes and helpers of the vector terminal stream decoder.
// ----------------------------------------------------------------------------
package vtsd_pkg;

    localparam int POS_W   = 21;
    localparam int COORD_W = 12;
    localparam int SCALE_W = 24;
    localparam int OFS_W   = 16;
    localparam int CW_W    = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic signed [POS_W:0] POS_MAX = 22'sd1048575;
    localparam logic signed [POS_W:0] POS_MIN = -22'sd1048576;
    localparam logic signed [COORD_W:0] Y_FLIP = 13'sd3120;

    localparam logic [7:0] CHR_BEL = 8'd7;
    localparam logic [7:0] CHR_ESC = 8'd27;
    localparam logic [7:0] CHR_GS  = 8'd29;
    localparam logic [7:0] CHR_US  = 8'd31;

    localparam logic [1:0] GRP_HIGH  = 2'b01;
    localparam logic [1:0] GRP_LOW_X = 2'b10;
    localparam logic [1:0] GRP_LOW_Y = 2'b11;

    typedef enum logic [1:0] {
        ACT_CHAR = 2'd0,
        ACT_MOVE = 2'd1,
        ACT_LINE = 2'd2
    } action_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COORD_SCALE = 2'd0,
        REG_X_OFFSET    = 2'd1,
        REG_Y_OFFSET    = 2'd2,
        REG_CHAR_WIDTH  = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic                    graph_mode;
        logic                    pen_up;
        logic                    low_y_seen;
        logic                    skip_next;
        logic [4:0]              high_x;
        logic [4:0]              high_y;
        logic [4:0]              low_y;
        logic [3:0]              extra_bits;
        logic [3:0]              extra_bits_saved;
        logic signed [POS_W-1:0] cursor_x;
        logic signed [POS_W-1:0] cursor_y;
    } state_t;

    localparam state_t STATE_RESET = '{
        graph_mode:       1'b0,
        pen_up:           1'b1,
        low_y_seen:       1'b0,
        skip_next:        1'b0,
        high_x:           5'd0,
        high_y:           5'd0,
        low_y:            5'd0,
        extra_bits:       4'd0,
        extra_bits_saved: 4'd0,
        cursor_x:         21'sd0,
        cursor_y:         21'sd0
    };

    typedef struct packed {
        logic                    emit;
        action_t                 action;
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic [6:0]              code;
    } result_t;

    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [POS_W:0] v);
        logic signed [POS_W-1:0] r;
        if (v > POS_MAX)
            r = POS_MAX[POS_W-1:0];
        else if (v < POS_MIN)
            r = POS_MIN[POS_W-1:0];
        else
            r = v[POS_W-1:0];
        return r;
    endfunction

endpackage

>>> rtl/core/vtsd_scale.sv
// ----------------------------------------------------------------------------
// vtsd_scale
// Q8.16 scaling of one signed coordinate, rounded, truncated toward zero.
// ----------------------------------------------------------------------------
module vtsd_scale (
    input  logic signed [vtsd_pkg::COORD_W:0]   coord,
    input  logic [vtsd_pkg::SCALE_W-1:0]        coord_scale,
    output logic signed [vtsd_pkg::POS_W-1:0]   pixel
);
    import vtsd_pkg::*;

    logic signed [37:0] prod;
    logic signed [37:0] num;
    logic               round_up;
    logic [POS_W:0]     quot;

    assign prod     = 38'(coord) * 38'($signed({1'b0, coord_scale}));
    assign num      = prod + 38'sd32768;
    assign round_up = num[37] && (num[15:0] != 16'd0);
    assign quot     = num[37:16] + {{POS_W{1'b0}}, round_up};
    assign pixel    = quot[POS_W-1:0];

endmodule

>>> rtl/core/vtsd_decode.sv
// ----------------------------------------------------------------------------
// vtsd_decode
// Byte parser: next parser state and the drawing result of one stream byte.
// ----------------------------------------------------------------------------
module vtsd_decode (
    input  vtsd_pkg::state_t              state,
    input  logic [7:0]                    stream_byte,
    input  logic                          last_byte,
    input  logic [vtsd_pkg::SCALE_W-1:0]  coord_scale,
    input  logic [vtsd_pkg::CW_W-1:0]     char_width,
    output vtsd_pkg::state_t              state_next,
    output vtsd_pkg::result_t             result
);
    import vtsd_pkg::*;

    logic [4:0]               v;
    logic [COORD_W-1:0]       xc;
    logic [COORD_W-1:0]       yc;
    logic signed [COORD_W:0]  dx;
    logic signed [COORD_W:0]  dy;
    logic signed [POS_W-1:0]  px;
    logic signed [POS_W-1:0]  py;
    logic signed [POS_W:0]    nx;
    logic signed [POS_W-1:0]  adv_x;
    state_t                   ns;

    assign v  = stream_byte[4:0];
    assign xc = {state.high_x, v, state.extra_bits[1:0]};
    assign yc = {state.high_y, state.low_y, state.extra_bits[3:2]};
    assign dx = $signed({1'b0, xc});
    assign dy = Y_FLIP - $signed({1'b0, yc});
    assign nx = {state.cursor_x[POS_W-1], state.cursor_x}
              + $signed({{(POS_W+1-CW_W){1'b0}}, char_width});
    assign adv_x = (nx > POS_MAX) ? POS_MAX[POS_W-1:0] : nx[POS_W-1:0];

    vtsd_scale u_scale_x (
        .coord       (dx),
        .coord_scale (coord_scale),
        .pixel       (px)
    );

    vtsd_scale u_scale_y (
        .coord       (dy),
        .coord_scale (coord_scale),
        .pixel       (py)
    );

    always_comb
    begin
        ns     = state;
        result = '{emit: 1'b0, action: ACT_CHAR, x: state.cursor_x,
                   y: state.cursor_y, code: 7'd0};
        priority if (state.skip_next)
        begin
            ns.skip_next = 1'b0;
        end
        else if (stream_byte == CHR_BEL)
        begin
            ns = state;
        end
        else if (stream_byte == CHR_US)
        begin
            ns.graph_mode = 1'b0;
        end
        else if (stream_byte == CHR_GS)
        begin
            ns.graph_mode = 1'b1;
            ns.pen_up     = 1'b1;
            ns.low_y_seen = 1'b0;
        end
        else if (stream_byte == CHR_ESC)
        begin
            ns.skip_next = 1'b1;
        end
        else if (stream_byte[7] || (stream_byte[6:5] == 2'b00))
        begin
            ns = state;
        end
        else if (!state.graph_mode)
        begin
            result.emit = 1'b1;
            result.code = stream_byte[6:0];
            ns.cursor_x = adv_x;
        end
        else
        begin
            unique case (stream_byte[6:5])
                GRP_HIGH:
                begin
                    if (state.low_y_seen)
                        ns.high_x = v;
                    else
                        ns.high_y = v;
                end
                GRP_LOW_X:
                begin
                    ns.cursor_x   = px;
                    ns.cursor_y   = py;
                    ns.pen_up     = 1'b0;
                    ns.low_y_seen = 1'b0;
                    result.emit   = 1'b1;
                    result.action = state.pen_up ? ACT_MOVE : ACT_LINE;
                    result.x      = px;
                    result.y      = py;
                end
                GRP_LOW_Y:
                begin
                    ns.low_y = v;
                    if (state.low_y_seen)
                        ns.extra_bits = state.extra_bits_saved;
                    else
                        ns.extra_bits_saved = v[3:0];
                    ns.low_y_seen = 1'b1;
                end
                default:
                begin
                    ns = state;
                end
            endcase
        end
        state_next = last_byte ? STATE_RESET : ns;
    end

endmodule

>>> rtl/core/vector_terminal_stream_decoder_core.sv
// ----------------------------------------------------------------------------
// vector_terminal_stream_decoder_core
// Vector terminal graphics stream decoder: one byte in, zero or one drawing
// item out (character, pen move or line), with scaled and offset positions.
// ----------------------------------------------------------------------------
//  channel | handshake           | payload
//  --------+---------------------+--------------------------------------------
//  in      | in_valid / in_stall | stream_byte, last_byte
//  out     | out_valid/out_stall | action, pos_x, pos_y, char_code
//  cfg     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
//  One byte per cycle sustained while no result is stalled. Each byte is
//  parsed and scaled in a single pass from the input register to the result
//  register, two 13x24 multipliers setting the path length.
//  Reset loads the register reset values and the parser idle state.
//  A stalled result holds the output register; a result-making byte then
//  waits in the input register, with in_stall high, until the result is taken.
// ----------------------------------------------------------------------------
module vector_terminal_stream_decoder_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [7:0]                         stream_byte,
    input  logic                               last_byte,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [1:0]                         action,
    output logic signed [vtsd_pkg::POS_W-1:0]  pos_x,
    output logic signed [vtsd_pkg::POS_W-1:0]  pos_y,
    output logic [6:0]                         char_code,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [vtsd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [vtsd_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import vtsd_pkg::*;

    logic [SCALE_W-1:0]       coord_scale_reg;
    logic signed [OFS_W-1:0]  x_offset_reg;
    logic signed [OFS_W-1:0]  y_offset_reg;
    logic [CW_W-1:0]          char_width_reg;

    logic                     in_valid_reg;
    logic [7:0]               byte_reg;
    logic                     last_reg;

    state_t                   state_reg;
    state_t                   state_next;
    result_t                  result;

    logic                     out_valid_reg;
    logic                     out_valid_next;
    action_t                  action_reg;
    logic signed [POS_W-1:0]  pos_x_reg;
    logic signed [POS_W-1:0]  pos_y_reg;
    logic [6:0]               char_code_reg;

    logic                     advance;
    logic                     in_take;
    logic signed [POS_W:0]    sum_x;
    logic signed [POS_W:0]    sum_y;

    vtsd_decode u_decode (
        .state       (state_reg),
        .stream_byte (byte_reg),
        .last_byte   (last_reg),
        .coord_scale (coord_scale_reg),
        .char_width  (char_width_reg),
        .state_next  (state_next),
        .result      (result)
    );

    assign advance  = in_valid_reg && (!result.emit || !out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    assign sum_x = {result.x[POS_W-1], result.x}
                 + (POS_W+1)'(x_offset_reg);
    assign sum_y = {result.y[POS_W-1], result.y}
                 + (POS_W+1)'(y_offset_reg);

    always_comb
    begin
        if (advance && result.emit)
            out_valid_next = 1'b1;
        else
            out_valid_next = out_valid_reg && out_stall;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coord_scale_reg <= 24'd16384;
            x_offset_reg    <= '0;
            y_offset_reg    <= '0;
            char_width_reg  <= 8'd8;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_COORD_SCALE: coord_scale_reg <= cfg_data[SCALE_W-1:0];
                REG_X_OFFSET:    x_offset_reg    <= cfg_data[OFS_W-1:0];
                REG_Y_OFFSET:    y_offset_reg    <= cfg_data[OFS_W-1:0];
                REG_CHAR_WIDTH:  char_width_reg  <= cfg_data[CW_W-1:0];
                default:         coord_scale_reg <= coord_scale_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            state_reg     <= STATE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;
            if (advance)
                state_reg <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            byte_reg <= stream_byte;
            last_reg <= last_byte;
        end
        if (advance && result.emit)
        begin
            action_reg    <= result.action;
            pos_x_reg     <= sat_pos(sum_x);
            pos_y_reg     <= sat_pos(sum_y);
            char_code_reg <= result.code;
        end
    end

    assign out_valid = out_valid_reg;
    assign action    = action_reg;
    assign pos_x     = pos_x_reg;
    assign pos_y     = pos_y_reg;
    assign char_code = char_code_reg;

`ifndef NO_ASSERTIONS
    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && last_reg) |=> (!state_reg.graph_mode && state_reg.pen_up
            && !state_reg.skip_next && !state_reg.low_y_seen))
        else $error("parser state not cleared after last byte");

    a_code_only_char: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (action != ACT_CHAR)) |-> (char_code == 7'd0))
        else $error("char_code set on a move or line item");

    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid)
        else $error("stalled result item lost");

    a_skip_consumes: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && state_reg.skip_next) |-> !result.emit)
        else $error("dropped byte produced a result");
`endif

endmodule

>>> tb/vector_terminal_stream_decoder_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vector_terminal_stream_decoder_core_tb
// Self-checking bench for the vector terminal stream decoder. Byte items are
// fed through the stall handshake while a local decoder model predicts each
// draw item; a monitor compares every accepted result against the oldest
// prediction. Directed tests cover text, vectors, escapes and register
// extremes, then random streams, with stray and malformed bytes, run under several register
// settings with random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module vector_terminal_stream_decoder_core_tb;

    import vtsd_pkg::*;

    localparam int SETTLE_CYCLES = 6;
    localparam int DRAIN_LIMIT   = 4000;
    localparam int PHASE_ITEMS   = 275;
    localparam int PIX_MAX       = 1048575;
    localparam int PIX_MIN       = -1048576;

    typedef struct {
        action_t                 act;
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic [6:0]              code;
    } draw_t;

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_stall;
    logic [7:0]                stream_byte;
    logic                      last_byte;
    logic                      out_valid;
    logic                      out_stall;
    logic [1:0]                action;
    logic signed [POS_W-1:0]   pos_x;
    logic signed [POS_W-1:0]   pos_y;
    logic [6:0]                char_code;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_IDX_W-1:0]      cfg_index;
    logic [CFG_DATA_W-1:0]     cfg_data;

    // decoder model: registers
    int unsigned px_scale = 16384;
    int          x_ofs    = 0;
    int          y_ofs    = 0;
    int          cw       = 8;

    // decoder model: parser state
    logic        st_graph;
    logic        st_pen_up;
    logic        st_low_y_seen;
    logic        st_skip;
    logic [4:0]  st_high_x;
    logic [4:0]  st_high_y;
    logic [4:0]  st_low_y;
    logic [3:0]  st_extra;
    logic [3:0]  st_extra_saved;
    int          cur_x;
    int          cur_y;

    draw_t       pending_draws[$];
    draw_t       head_draw;
    int          errors = 0;
    int          useful_items = 0;

    // sender and receiver idling controls
    int          gap_pct = 0;
    int          gap_max = 1;
    int          burst_max = 1;
    int          burst_left = 0;
    int          stall_pct = 0;
    int          stall_run_max = 1;
    int          stall_run_left = 0;
    logic        stall_run_on = 1'b0;
    int          hold_left = 0;

    vector_terminal_stream_decoder_core uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .stream_byte (stream_byte),
        .last_byte   (last_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .action      (action),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .char_code   (char_code),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    task automatic report_error(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        errors++;
    endtask

    function automatic void clear_parser();
        st_graph       = 1'b0;
        st_pen_up      = 1'b1;
        st_low_y_seen  = 1'b0;
        st_skip        = 1'b0;
        st_high_x      = '0;
        st_high_y      = '0;
        st_low_y       = '0;
        st_extra       = '0;
        st_extra_saved = '0;
        cur_x          = 0;
        cur_y          = 0;
    endfunction

    function automatic logic signed [POS_W-1:0] clamp_pos(input longint v);
        longint c;
        c = v;
        if (c > PIX_MAX)
            c = PIX_MAX;
        else if (c < PIX_MIN)
            c = PIX_MIN;
        return c[POS_W-1:0];
    endfunction

    function automatic int scale_to_pixel(input int d);
        longint num;
        num = longint'(d) * longint'(px_scale) + 64'sd32768;
        return int'(num / 64'sd65536);
    endfunction

    function automatic void push_draw(input action_t act, input int px, input int py,
                                      input logic [6:0] code);
        draw_t d;
        d.act  = act;
        d.x    = clamp_pos(longint'(px) + x_ofs);
        d.y    = clamp_pos(longint'(py) + y_ofs);
        d.code = code;
        pending_draws.push_back(d);
    endfunction

    function automatic void decode_stream_byte(input logic [7:0] b, input logic lb);
        logic [4:0] v;
        int         xc;
        int         yc;
        longint     nx;
        v = b[4:0];
        if (st_skip)
        begin
            st_skip = 1'b0;
        end
        else if (b == CHR_US)
        begin
            st_graph = 1'b0;
            useful_items++;
        end
        else if (b == CHR_GS)
        begin
            st_graph      = 1'b1;
            st_pen_up     = 1'b1;
            st_low_y_seen = 1'b0;
            useful_items++;
        end
        else if (b == CHR_ESC)
        begin
            st_skip = 1'b1;
            useful_items++;
        end
        else if (b >= 8'd32 && b <= 8'd127)
        begin
            useful_items++;
            if (!st_graph)
            begin
                push_draw(ACT_CHAR, cur_x, cur_y, b[6:0]);
                nx = longint'(cur_x) + cw;
                cur_x = (nx > PIX_MAX) ? PIX_MAX : int'(nx);
            end
            else if (b <= 8'd63)
            begin
                if (st_low_y_seen)
                    st_high_x = v;
                else
                    st_high_y = v;
            end
            else if (b <= 8'd95)
            begin
                xc = {st_high_x, v, st_extra[1:0]};
                yc = {st_high_y, st_low_y, st_extra[3:2]};
                cur_x = scale_to_pixel(xc);
                cur_y = scale_to_pixel(int'(Y_FLIP) - yc);
                push_draw(st_pen_up ? ACT_MOVE : ACT_LINE, cur_x, cur_y, 7'd0);
                st_pen_up     = 1'b0;
                st_low_y_seen = 1'b0;
            end
            else
            begin
                if (st_low_y_seen)
                    st_extra = st_extra_saved;
                else
                    st_extra_saved = v[3:0];
                st_low_y      = v;
                st_low_y_seen = 1'b1;
            end
        end
        if (lb)
            clear_parser();
    endfunction

    function automatic logic [7:0] addr_byte(input logic [1:0] grp, input logic [4:0] v);
        return {1'b0, grp, v};
    endfunction

    function automatic logic random_last();
        return ($urandom_range(199) < 3);
    endfunction

    task automatic set_idling(input int gp, input int gm, input int bm,
                              input int sp, input int sr);
        gap_pct       = gp;
        gap_max       = gm;
        burst_max     = bm;
        burst_left    = 0;
        stall_pct     = sp;
        stall_run_max = sr;
    endtask

    task automatic send_item(input logic [7:0] b, input logic lb);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, burst_max);
            if (gap_pct > 0 && $urandom_range(99) < gap_pct)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, gap_max)) @(posedge clk);
            end
        end
        in_valid    <= 1'b1;
        stream_byte <= b;
        last_byte   <= lb;
        do
            @(posedge clk);
        while (in_stall);
        decode_stream_byte(b, lb);
        burst_left--;
    endtask

    task automatic wait_for_results();
        int n;
        n = 0;
        in_valid <= 1'b0;
        while (pending_draws.size() != 0 && n < DRAIN_LIMIT)
        begin
            @(posedge clk);
            n++;
        end
        if (pending_draws.size() != 0)
        begin
            report_error($sformatf("%0d draw items never arrived", pending_draws.size()));
            pending_draws.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apply_config(input logic [23:0] scale, input int xo, input int yo,
                                input int width);
        logic [23:0] data [4];
        logic [31:0] r;
        int          i;
        r = $urandom;
        data[0] = scale;
        data[1] = {r[7:0], xo[15:0]};
        data[2] = {r[15:8], yo[15:0]};
        data[3] = {r[31:16], width[7:0]};
        for (i = 0; i < 4; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= cfg_reg_t'(i);
            cfg_data  <= data[i];
            do
                @(posedge clk);
            while (!cfg_ready);
            case (cfg_reg_t'(i))
                REG_COORD_SCALE: px_scale = data[i];
                REG_X_OFFSET:    x_ofs = int'($signed(data[i][15:0]));
                REG_Y_OFFSET:    y_ofs = int'($signed(data[i][15:0]));
                REG_CHAR_WIDTH:  cw = data[i][7:0];
                default:         ;
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    // receiver: hold-off first, otherwise random stall runs
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else if (stall_pct == 0)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (stall_run_left == 0)
            begin
                stall_run_on   = ($urandom_range(99) < stall_pct);
                stall_run_left = $urandom_range(1, stall_run_max);
            end
            out_stall <= stall_run_on;
            stall_run_left--;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_draws.size() == 0)
            begin
                report_error($sformatf("unexpected item action=%0d x=%0d y=%0d code=%0d",
                                       action, pos_x, pos_y, char_code));
            end
            else
            begin
                head_draw = pending_draws.pop_front();
                if (action !== head_draw.act)
                    report_error($sformatf("action %0d, want %0d", action, head_draw.act));
                if (pos_x !== head_draw.x)
                    report_error($sformatf("pos_x %0d, want %0d", pos_x, head_draw.x));
                if (pos_y !== head_draw.y)
                    report_error($sformatf("pos_y %0d, want %0d", pos_y, head_draw.y));
                if (char_code !== head_draw.code)
                    report_error($sformatf("char_code %0d, want %0d", char_code,
                                           head_draw.code));
            end
        end
    end

    task automatic test_alpha_text();
        send_item("A", 1'b0);
        send_item(8'd32, 1'b0);
        send_item(8'd127, 1'b0);
        send_item(CHR_BEL, 1'b0);
        send_item(8'h01, 1'b0);
        send_item(8'h80, 1'b0);
        send_item(8'hFF, 1'b0);
        wait_for_results();
    endtask

    task automatic test_graph_vectors();
        send_item(CHR_GS, 1'b0);
        send_item(addr_byte(GRP_HIGH, 5'd31), 1'b0);
        send_item(addr_byte(GRP_LOW_Y, 5'b01111), 1'b0);
        send_item(addr_byte(GRP_LOW_Y, 5'd31), 1'b0);
        send_item(addr_byte(GRP_HIGH, 5'd31), 1'b0);
        send_item(addr_byte(GRP_LOW_X, 5'd31), 1'b0);
        send_item(addr_byte(GRP_LOW_X, 5'd0), 1'b0);
        send_item(CHR_US, 1'b0);
        send_item("B", 1'b0);
        wait_for_results();
    endtask

    task automatic test_escape_and_last();
        send_item(CHR_ESC, 1'b0);
        send_item("C", 1'b0);
        send_item("D", 1'b0);
        send_item(CHR_ESC, 1'b1);
        send_item("E", 1'b0);
        send_item(CHR_ESC, 1'b0);
        send_item("F", 1'b1);
        send_item("G", 1'b0);
        wait_for_results();
    endtask

    task automatic test_register_extremes();
        apply_config(24'hFFFFFF, 32767, -32768, 255);
        send_item(CHR_GS, 1'b0);
        send_item(addr_byte(GRP_HIGH, 5'd31), 1'b0);
        send_item(addr_byte(GRP_LOW_Y, 5'd31), 1'b0);
        send_item(addr_byte(GRP_HIGH, 5'd31), 1'b0);
        send_item(addr_byte(GRP_LOW_X, 5'd31), 1'b0);
        send_item(CHR_US, 1'b0);
        send_item("~", 1'b0);
        send_item("~", 1'b0);
        send_item("~", 1'b1);
        wait_for_results();
        apply_config(24'd0, -32768, 32767, 0);
        send_item(CHR_GS, 1'b0);
        send_item(addr_byte(GRP_LOW_X, 5'd17), 1'b0);
        wait_for_results();
    endtask

    task automatic test_backpressure();
        int i;
        apply_config(24'd16384, 0, 0, 8);
        set_idling(0, 1, 1, 0, 1);
        send_item(CHR_US, 1'b0);
        hold_left = 300;
        for (i = 0; i < 40; i++)
            send_item(8'($urandom_range(32, 127)), 1'b0);
        wait_for_results();
    endtask

    task automatic send_random_sequence();
        int kind;
        int n;
        int i;
        int r;
        kind = $urandom_range(99);
        if (kind < 55)
        begin
            if ($urandom_range(3) == 0)
                send_item(CHR_GS, random_last());
            n = $urandom_range(1, 4);
            for (i = 0; i < n; i++)
            begin
                if ($urandom_range(1))
                    send_item(addr_byte(GRP_HIGH, 5'($urandom)), random_last());
                repeat ($urandom_range(2))
                    send_item(addr_byte(GRP_LOW_Y, 5'($urandom)), random_last());
                if ($urandom_range(1))
                    send_item(addr_byte(GRP_HIGH, 5'($urandom)), random_last());
                send_item(addr_byte(GRP_LOW_X, 5'($urandom)), random_last());
            end
        end
        else if (kind < 80)
        begin
            send_item(CHR_US, random_last());
            repeat ($urandom_range(1, 8))
                send_item(8'($urandom_range(32, 127)), random_last());
        end
        else
        begin
            n = $urandom_range(1, 4);
            for (i = 0; i < n; i++)
            begin
                r = $urandom_range(3);
                if (r < 2)
                begin
                    send_item(8'($urandom), random_last());
                end
                else if (r == 2)
                begin
                    send_item(CHR_ESC, random_last());
                    send_item(8'($urandom), random_last());
                end
                else
                begin
                    case ($urandom_range(3))
                        0:       send_item(CHR_BEL, random_last());
                        1:       send_item(CHR_US, random_last());
                        2:       send_item(CHR_GS, random_last());
                        default: send_item(8'($urandom_range(31)), random_last());
                    endcase
                end
            end
        end
    endtask

    task automatic test_random_stream();
        int ph;
        int start;
        for (ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0:
                begin
                    apply_config(24'd16384, 0, 0, 8);
                    set_idling(0, 1, 1, 0, 1);
                end
                1:
                begin
                    apply_config(24'hFFFFFF, 32767, -32768, 255);
                    set_idling(30, 6, 12, 30, 6);
                end
                2:
                begin
                    apply_config(24'd0, -32768, 32767, 0);
                    set_idling(50, 10, 4, 50, 8);
                end
                default:
                begin
                    apply_config(24'($urandom_range(24'hFFFFFF)),
                                 $urandom_range(65535) - 32768,
                                 $urandom_range(65535) - 32768,
                                 $urandom_range(255));
                    set_idling($urandom_range(40), $urandom_range(1, 8),
                               $urandom_range(1, 16), $urandom_range(40),
                               $urandom_range(1, 8));
                end
            endcase
            start = useful_items;
            while (useful_items - start < PHASE_ITEMS)
                send_random_sequence();
            // pause until everything is back before the next register write
            wait_for_results();
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        stream_byte = '0;
        last_byte   = 1'b0;
        out_stall   = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = REG_COORD_SCALE;
        cfg_data    = '0;
        clear_parser();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_alpha_text();
        test_graph_vectors();
        test_escape_and_last();
        test_register_extremes();
        test_backpressure();
        test_random_stream();

        wait_for_results();
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
